// ===== rtl/bps_pkg.sv =====
// Shared types, constants and codes of the bitmap priority scheduler.
package bps_pkg;

    localparam int NUM_PRIO   = 32;
    localparam int TICK_WIDTH = 16;
    localparam int PRIO_W     = 6;
    localparam int TICKS_W    = 16;
    localparam int MASK_W     = 32;
    localparam int IDX_W      = $clog2(NUM_PRIO);

    typedef logic [PRIO_W-1:0]     prio_t;
    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [NUM_PRIO-1:0]   pmask_t;

    localparam prio_t NO_THREAD = prio_t'(33);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_DELAY = 2'd1,
        ACT_START = 2'd2,
        ACT_SCHED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PRIO  = 2'd1,
        ST_BAD_DELAY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_WALK  = 2'd2,
        S_SCHED = 2'd3
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic walk_start;
        logic walk;
        logic sched;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_tick;
        logic idx_last;
    } dp_stat_t;

endpackage

// ===== rtl/bps_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bps_ctrl.sv =====
// Sequencing state machine of the scheduler.
module bps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bps_pkg::dp_stat_t dp_stat,
    output bps_pkg::cmd_t     cmd,
    output logic              busy
);
    import bps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dp_stat.is_tick)
                begin
                    // issue the read of the first counter
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_SCHED;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (dp_stat.idx_last)
                begin
                    state_next = S_SCHED;
                end
            end
            S_SCHED:
            begin
                cmd.sched  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/bps_datapath.sv =====
// Scheduler state, counter walk and priority encode.
module bps_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bps_pkg::cmd_t                  cmd,
    output bps_pkg::dp_stat_t              dp_stat,
    input  logic [1:0]                     action,
    input  logic [bps_pkg::PRIO_W-1:0]     prio,
    input  logic [bps_pkg::TICKS_W-1:0]    ticks,
    output logic                           done,
    output logic [bps_pkg::PRIO_W-1:0]     next_prio,
    output logic                           switch_request,
    output logic [bps_pkg::MASK_W-1:0]     ready_mask,
    output logic [1:0]                     status
);
    import bps_pkg::*;

    action_t              action_reg;
    prio_t                prio_in_reg;
    tick_t                ticks_in_reg;
    prio_t                running_reg, running_next;
    logic [NUM_PRIO:0]    regmask_reg, regmask_next;
    pmask_t               ready_reg, ready_next;
    pmask_t               delayed_reg, delayed_next;
    idx_t                 idx_reg, idx_next;
    status_t              status_reg, status_next;
    logic                 switch_reg, switch_next;
    logic                 done_reg;

    logic                 ram_we;
    idx_t                 ram_waddr;
    tick_t                ram_wdata;
    idx_t                 ram_raddr;
    tick_t                ram_rdata;

    logic [NUM_PRIO:0]    start_hot;
    pmask_t               run_hot;
    tick_t                dec;
    prio_t                top;
    logic                 start_bad;
    logic                 delay_ok;

    bps_ram #(
        .WIDTH (TICK_WIDTH),
        .DEPTH (NUM_PRIO)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one-hot decodes of the start priority and the running priority
    always_comb
    begin
        for (int p = 0; p <= NUM_PRIO; p++)
        begin
            start_hot[p] = (prio_in_reg == prio_t'(p));
        end
        for (int i = 0; i < NUM_PRIO; i++)
        begin
            run_hot[i] = (running_reg == prio_t'(i + 1));
        end
    end

    // highest ready priority, 0 when none
    always_comb
    begin
        top = '0;
        for (int i = 0; i < NUM_PRIO; i++)
        begin
            if (ready_reg[i])
            begin
                top = prio_t'(i + 1);
            end
        end
    end

    assign start_bad = (prio_in_reg > prio_t'(NUM_PRIO)) || (|(start_hot & regmask_reg));
    assign delay_ok  = (running_reg != '0) && (running_reg <= prio_t'(NUM_PRIO))
                       && (ticks_in_reg != '0);
    assign dec       = ram_rdata - tick_t'(1);
    assign ram_raddr = cmd.walk ? idx_t'(idx_reg + 1'b1) : '0;

    always_comb
    begin
        running_next = running_reg;
        regmask_next = regmask_reg;
        ready_next   = ready_reg;
        delayed_next = delayed_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        switch_next  = switch_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = dec;

        if (cmd.exec)
        begin
            status_next = ST_OK;
            case (action_reg)
                ACT_DELAY:
                begin
                    if (delay_ok)
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = idx_t'(running_reg - 1'b1);
                        ram_wdata    = ticks_in_reg;
                        ready_next   = ready_reg & ~run_hot;
                        delayed_next = delayed_reg | run_hot;
                    end
                    else
                    begin
                        status_next = ST_BAD_DELAY;
                    end
                end
                ACT_START:
                begin
                    if (start_bad)
                    begin
                        status_next = ST_BAD_PRIO;
                    end
                    else
                    begin
                        regmask_next = regmask_reg | start_hot;
                        ready_next   = ready_reg | start_hot[NUM_PRIO:1];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.walk_start)
        begin
            status_next = ST_OK;
            idx_next    = '0;
        end

        // retire one counter per cycle; read of the next one is in flight
        if (cmd.walk)
        begin
            if (delayed_reg[idx_reg])
            begin
                ram_we = 1'b1;
                if (dec == '0)
                begin
                    ready_next[idx_reg]   = 1'b1;
                    delayed_next[idx_reg] = 1'b0;
                end
            end
            if (!dp_stat.idx_last)
            begin
                idx_next = idx_t'(idx_reg + 1'b1);
            end
        end

        if (cmd.sched)
        begin
            switch_next  = (top != running_reg);
            running_next = top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= NO_THREAD;
            regmask_reg <= (NUM_PRIO + 1)'(1);
            ready_reg   <= '0;
            delayed_reg <= '0;
            idx_reg     <= '0;
            status_reg  <= ST_OK;
            switch_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            regmask_reg <= regmask_next;
            ready_reg   <= ready_next;
            delayed_reg <= delayed_next;
            idx_reg     <= idx_next;
            status_reg  <= status_next;
            switch_reg  <= switch_next;
            done_reg    <= cmd.sched;
        end
    end

    // transaction payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg   <= action_t'(action);
            prio_in_reg  <= prio;
            ticks_in_reg <= tick_t'(ticks);
        end
    end

    assign dp_stat.is_tick  = (action_reg == ACT_TICK);
    assign dp_stat.idx_last = (idx_reg == idx_t'(NUM_PRIO - 1));

    assign done           = done_reg;
    assign next_prio      = running_reg;
    assign switch_request = switch_reg;
    assign ready_mask     = MASK_W'(ready_reg);
    assign status         = status_reg;

endmodule

// ===== rtl/bitmap_priority_scheduler.sv =====
// Top level of the bitmap priority thread scheduler.
//
//  channel  | handshake       | payload
//  ---------+-----------------+------------------------------------------------
//  command  | start, busy     | action, prio, ticks
//  result   | done (strobe)   | next_prio, switch_request, ready_mask, status
//
// A transaction is taken when start is high and busy is low.
// Start, delay and schedule-only actions pass through the execute and schedule
// states to done. A tick walks the NUM_PRIO counters between the two: the timeout
// counters sit in one RAM with a single read port, so the walk retires one
// counter per cycle before the priority encode.
// The result is on the ports for the single cycle that done is high; the
// receiver cannot stall it, and a new command may be taken in that cycle.
// Reset (rst_n, asynchronous, active low) leaves no thread running, only the
// idle level registered and the ready and delayed sets empty; the counters
// themselves are not cleared, since each is written before its value is used.
module bitmap_priority_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [bps_pkg::PRIO_W-1:0]    prio,
    input  logic [bps_pkg::TICKS_W-1:0]   ticks,
    output logic                          done,
    output logic [bps_pkg::PRIO_W-1:0]    next_prio,
    output logic                          switch_request,
    output logic [bps_pkg::MASK_W-1:0]    ready_mask,
    output logic [1:0]                    status
);
    import bps_pkg::*;

    cmd_t     cmd;
    dp_stat_t dp_stat;

    // Sequence each transaction: capture, act or walk the counters, encode.
    bps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Hold the masks, running thread and counters; drive the result ports.
    bps_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_stat        (dp_stat),
        .action         (action),
        .prio           (prio),
        .ticks          (ticks),
        .done           (done),
        .next_prio      (next_prio),
        .switch_request (switch_request),
        .ready_mask     (ready_mask),
        .status         (status)
    );

endmodule
